// File: hw/rtl/lsrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsrs_pkg;

   // Cells in one strip row; the row ports stay 64 bits wide
   localparam int STRIP_WIDTH = 64;
   localparam int ROW_BITS    = 64;
   localparam int COUNT_BITS  = 7;

   // Live cells of the strip and the easternmost cell of it
   localparam logic [ROW_BITS-1:0] STRIP_MASK = {ROW_BITS{1'b1}} >> (ROW_BITS - STRIP_WIDTH);
   localparam logic [ROW_BITS-1:0] STRIP_TOP  = {{(ROW_BITS-1){1'b0}}, 1'b1} << (STRIP_WIDTH - 1);

   // Neighbour sums of one row, each as a low and a high bit plane
   typedef struct packed {
      logic [ROW_BITS-1:0] pair_low;
      logic [ROW_BITS-1:0] pair_high;
      logic [ROW_BITS-1:0] triple_low;
      logic [ROW_BITS-1:0] triple_high;
   } row_sums_type;

   // Step control from the pipeline to the generation core
   typedef struct packed {
      logic step;
      logic first_row;
   } core_ctrl_type;

endpackage

`default_nettype wire

// File: hw/rtl/lsrs_row_sums.sv
`timescale 1ns / 1ps
`default_nettype none

module lsrs_row_sums
   import lsrs_pkg::*;
(
   input  wire logic [ROW_BITS-1:0] row_cells,
   input  wire logic                west_bit,
   input  wire logic                east_bit,
   output row_sums_type             sums
);

   logic [ROW_BITS-1:0] from_west;
   logic [ROW_BITS-1:0] from_east;
   logic [ROW_BITS-1:0] pair_low;
   logic [ROW_BITS-1:0] pair_high;

   // Shift in the neighbouring strips' edge cells
   assign from_west = ((row_cells << 1) & STRIP_MASK) | {{(ROW_BITS-1){1'b0}}, west_bit};
   assign from_east = (row_cells >> 1) | (east_bit ? STRIP_TOP : '0);

   // Half adder for the pair, full adder for the triple
   assign pair_low  = from_west ^ from_east;
   assign pair_high = from_west & from_east;

   assign sums.pair_low    = pair_low;
   assign sums.pair_high   = pair_high;
   assign sums.triple_low  = row_cells ^ pair_low;
   assign sums.triple_high = (row_cells & pair_low) | pair_high;

endmodule

`default_nettype wire

// File: hw/rtl/lsrs_gen_core.sv
`timescale 1ns / 1ps
`default_nettype none

module lsrs_gen_core
   import lsrs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire core_ctrl_type       ctrl,
   input  wire logic [ROW_BITS-1:0] row_cells,
   input  wire logic                west_bit,
   input  wire logic                east_bit,
   output logic      [ROW_BITS-1:0] next_row_cells
);

   row_sums_type        sums;
   logic [ROW_BITS-1:0] row_masked;

   logic [ROW_BITS-1:0] above_tl_ff, above_tl_in;
   logic [ROW_BITS-1:0] above_th_ff, above_th_in;
   logic [ROW_BITS-1:0] mid_pl_ff;
   logic [ROW_BITS-1:0] mid_ph_ff;
   logic [ROW_BITS-1:0] mid_tl_ff;
   logic [ROW_BITS-1:0] mid_th_ff;
   logic [ROW_BITS-1:0] mid_cells_ff;

   logic [ROW_BITS-1:0] s_low;
   logic [ROW_BITS-1:0] a0;
   logic [ROW_BITS-1:0] a1;

   assign row_masked = row_cells & STRIP_MASK;

   lsrs_row_sums u_row_sums (
      .row_cells (row_masked),
      .west_bit  (west_bit),
      .east_bit  (east_bit),
      .sums      (sums)
   );

   // Full adder over the three low planes, then the B3/S23 rule
   assign s_low = above_tl_ff ^ mid_pl_ff;
   assign a0    = s_low ^ sums.triple_low;
   assign a1    = (above_tl_ff & mid_pl_ff) | (s_low & sums.triple_low);

   assign next_row_cells = (a1 ^ above_th_ff ^ mid_ph_ff ^ sums.triple_high)
                         & ((a1 | above_th_ff) ^ (mid_ph_ff | sums.triple_high))
                         & (a0 | mid_cells_ff)
                         & STRIP_MASK;

   // A first row puts a dead row above the middle one
   assign above_tl_in = ctrl.first_row ? '0 : mid_tl_ff;
   assign above_th_in = ctrl.first_row ? '0 : mid_th_ff;

   // Advance the three-row window on each row taken
   always_ff @(posedge clock) begin
      if (reset) begin
         above_tl_ff  <= '0;
         above_th_ff  <= '0;
         mid_pl_ff    <= '0;
         mid_ph_ff    <= '0;
         mid_tl_ff    <= '0;
         mid_th_ff    <= '0;
         mid_cells_ff <= '0;
      end else if (ctrl.step) begin
         above_tl_ff  <= above_tl_in;
         above_th_ff  <= above_th_in;
         mid_pl_ff    <= sums.pair_low;
         mid_ph_ff    <= sums.pair_high;
         mid_tl_ff    <= sums.triple_low;
         mid_th_ff    <= sums.triple_high;
         mid_cells_ff <= row_masked;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/lsrs_pop_count.sv
`timescale 1ns / 1ps
`default_nettype none

module lsrs_pop_count
   import lsrs_pkg::*;
(
   input  wire logic [ROW_BITS-1:0]   cells,
   output logic      [COUNT_BITS-1:0] count
);

   logic [1:0] lvl1 [32];
   logic [2:0] lvl2 [16];
   logic [3:0] lvl3 [8];
   logic [4:0] lvl4 [4];
   logic [5:0] lvl5 [2];

   // Add neighbouring partial counts level by level
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         lvl1[i] = {1'b0, cells[2*i]} + {1'b0, cells[2*i+1]};
      end
      for (int i = 0; i < 16; i++) begin
         lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         lvl5[i] = {1'b0, lvl4[2*i]} + {1'b0, lvl4[2*i+1]};
      end
   end

   assign count = {1'b0, lvl5[0]} + {1'b0, lvl5[1]};

endmodule

`default_nettype wire

// File: hw/rtl/life_strip_row_stepper.sv
`timescale 1ns / 1ps
`default_nettype none

// Game of Life row stepper for one vertical strip (born on 3, survives on 2 or 3).
// Request channel: one strip row per transfer with its west and east edge cells;
// first_row marks the top of a strip and only loads the row window, giving no
// response. Every later row produces one response: the next generation of the
// row before it, with its live count when csr_wr_data last written was 1.
// The last row of a strip is never answered.
// Pipeline: input register, generation stage, result register. A request passes
// through them in that order to its response; one row is taken per cycle
// when the response side does not stall. The next-row logic is combinational
// from the row window and the row in the input register.
// When rsp_stall is high the result holds; req_stall follows it in the same
// cycle once the stages before the result are full, so at most two more
// answered rows are taken before req_stall rises (a first row fills no stage
// after the input register and does not count towards them).
// Reset empties the pipeline, clears the row window to dead rows and sets live
// counting on. A row sent without a first row before it sees a dead row above.

module life_strip_row_stepper
   import lsrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [ROW_BITS-1:0]   req_row_cells,
   input  wire logic                  req_west_bit,
   input  wire logic                  req_east_bit,
   input  wire logic                  req_first_row,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [ROW_BITS-1:0]   rsp_next_row_cells,
   output logic      [COUNT_BITS-1:0] rsp_live_count
);

   logic                  count_en_ff;

   logic                  in_valid_ff;
   logic [ROW_BITS-1:0]   in_row_ff;
   logic                  in_west_ff;
   logic                  in_east_ff;
   logic                  in_first_ff;

   logic                  gen_valid_ff;
   logic [ROW_BITS-1:0]   gen_row_ff;

   logic                  out_valid_ff;
   logic [ROW_BITS-1:0]   out_row_ff;
   logic [COUNT_BITS-1:0] out_count_ff, out_count_in;

   logic                  out_ready;
   logic                  gen_move;
   logic                  gen_ready;
   logic                  in_move;
   logic                  req_take;
   core_ctrl_type         core_ctrl;
   logic [ROW_BITS-1:0]   core_next;
   logic [COUNT_BITS-1:0] pop;

   // Handshake chain, back to front
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign gen_move  = gen_valid_ff && out_ready;
   assign gen_ready = !gen_valid_ff || gen_move;
   assign in_move   = in_valid_ff && gen_ready;
   assign req_stall = in_valid_ff && !gen_ready;
   assign req_take  = req_valid && !req_stall;

   // Live count enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         count_en_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (in_move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_row_ff   <= req_row_cells;
         in_west_ff  <= req_west_bit;
         in_east_ff  <= req_east_bit;
         in_first_ff <= req_first_row;
      end
   end

   // Generation stage: window advances as the row leaves the input register
   assign core_ctrl.step      = in_move;
   assign core_ctrl.first_row = in_first_ff;

   lsrs_gen_core u_gen_core (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (core_ctrl),
      .row_cells      (in_row_ff),
      .west_bit       (in_west_ff),
      .east_bit       (in_east_ff),
      .next_row_cells (core_next)
   );

   // Hold the next row; a first row leaves no result behind
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_valid_ff <= 1'b0;
      end else if (in_move) begin
         gen_valid_ff <= !in_first_ff;
      end else if (gen_move) begin
         gen_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         gen_row_ff <= core_next;
      end
   end

   // Count live cells into the result register
   lsrs_pop_count u_pop_count (
      .cells (gen_row_ff),
      .count (pop)
   );

   assign out_count_in = count_en_ff ? pop : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (gen_move) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (gen_move) begin
         out_row_ff   <= gen_row_ff;
         out_count_ff <= out_count_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_next_row_cells = out_row_ff;
   assign rsp_live_count     = out_count_ff;

endmodule

`default_nettype wire
